[sv/uri_percent_decoder_defines.svh]
// Assertion macros for the checker file.
`ifndef URI_PERCENT_DECODER_DEFINES_SVH
`define URI_PERCENT_DECODER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define UPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("upd check failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define UPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("upd check failed: next-cycle implication");

`endif

[sv/upd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and helpers for the URI percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] CH_QUESTION = 8'h3f;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_CASE_BIT = 8'h20;
   localparam logic [7:0] CH_DEL      = 8'h7f;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_F  = 8'h66;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [3:0] DIGIT_TEN   = 4'd10;

   localparam int CSR_ADDR_BITS = 3;
   localparam int QUEUE_DEPTH   = 2;

   // register index taken from paddr (one register, 4-byte spacing)
   localparam logic CSR_IDX_MODE = 1'b0;

   typedef enum logic [1:0] {
      PHASE_PLAIN  = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2
   } upd_phase_type;

   // One run of results caused by one input byte; count 0 = status only.
   typedef struct packed {
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [1:0]  count;
      logic [15:0] bad_count;
      logic        stop_hit;
      logic        done;
   } upd_job_type;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [7:0] low;
      low = ch | CH_CASE_BIT;
      if (ch >= CH_ZERO && ch <= CH_NINE)
         hex_decode = {1'b1, ch[3:0]};
      else if (low >= CH_LOWER_A && low <= CH_LOWER_F)
         hex_decode = {1'b1, 4'(low[3:0] + 4'd9)};
      else
         hex_decode = 5'd0;
   endfunction

   // restored first digit, lower case
   function automatic logic [7:0] hex_char(input logic [3:0] h);
      if (h < DIGIT_TEN)
         hex_char = {4'h3, h};
      else
         hex_char = 8'(CH_LOWER_A - 8'(DIGIT_TEN) + {4'h0, h});
   endfunction

endpackage

[sv/uri_percent_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming %XX decoder with URI/redirect stop rules and a bad-escape count.
// ----------------------------------------------------------------------------
//  port group  | role                   | transaction
//  req_*       | source byte in         | req_valid high, req_stall low
//  rsp_*       | decoded result out     | rsp_valid high, rsp_stall low
//  csr_*       | APB register access    | psel, penable, pready high (pwrite for a write)
//
//  One source byte is taken per cycle while req_stall is low. A byte causing
//  two results or a restored escape (three results) holds the result side
//  while its results go out in turn. The two-entry job queue takes one more
//  byte behind it, then req_stall rises. An accepted byte goes through the job
//  queue and then the output register.
//  Reset is synchronous and clears decode state, queue, output and mode.
//  A stalled result holds in the output register; the front fills the queue.
// ----------------------------------------------------------------------------
module uri_percent_decoder #(
   parameter int ERROR_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // source bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic [15:0] rsp_bad_count,
   output logic        rsp_stop_hit,
   output logic        rsp_string_done,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [upd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]           mode_ff;
   logic                 csr_hit;
   logic                 push, pop, q_empty, q_full;
   upd_pkg::upd_job_type push_job, head_job;

   // Register 0 (unescape_mode) answers at byte addresses 0 to 3 (paddr[2] low);
   // addresses 4 to 7 are ignored on write and read as zero.
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[upd_pkg::CSR_ADDR_BITS-1] == upd_pkg::CSR_IDX_MODE;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         mode_ff <= csr_pwdata[1:0];
      end
   end

   assign csr_prdata = csr_hit ? {30'd0, mode_ff} : 32'd0;

   // Front: classifies each byte and keeps the escape state.
   upd_front #(
      .ERROR_COUNT_BITS(ERROR_COUNT_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .mode              (mode_ff),
      .queue_full        (q_full),
      .push              (push),
      .job               (push_job)
   );

   // Queue: decouples the two halves.
   upd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Back: one result transaction per cycle into the output register while not stalled.
   upd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .queue_empty     (q_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_bad_count   (rsp_bad_count),
      .rsp_stop_hit    (rsp_stop_hit),
      .rsp_string_done (rsp_string_done)
   );

endmodule

[sv/upd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front
// Takes source bytes, runs the escape FSM, emits a job per byte with output.
// ----------------------------------------------------------------------------
module upd_front #(
   parameter int ERROR_COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_string,
   input  logic [1:0]          mode,
   input  logic                queue_full,
   output logic                push,
   output upd_pkg::upd_job_type job
);

   upd_pkg::upd_phase_type phase_ff, phase_in;
   logic [3:0]  nib_ff, nib_in;
   logic [7:0]  first_ff, first_in;
   logic [ERROR_COUNT_BITS-1:0] tally_ff, tally_in;
   logic        stop_ff, stop_in;
   logic        accept, bad, uri, redir, letter;
   logic [4:0]  hex;
   logic [7:0]  val, b0, b1, b2;
   logic [1:0]  cnt;
   logic [15:0] rep;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign uri       = mode[0];
   assign redir     = mode[1];
   assign hex       = upd_pkg::hex_decode(req_in_byte);
   assign val       = {nib_ff, hex[3:0]};
   assign letter    = hex[3:0] >= upd_pkg::DIGIT_TEN;

   always_comb begin
      phase_in = phase_ff;
      nib_in   = nib_ff;
      first_in = first_ff;
      stop_in  = stop_ff;
      bad      = 1'b0;
      cnt      = 2'd0;
      b0       = 8'd0;
      b1       = 8'd0;
      b2       = 8'd0;
      if (!stop_ff) begin
         case (phase_ff)
            upd_pkg::PHASE_PLAIN: begin
               if (req_in_byte == upd_pkg::CH_QUESTION && (uri || redir)) begin
                  b0      = req_in_byte;
                  cnt     = 2'd1;
                  stop_in = 1'b1;
               end else if (req_in_byte == upd_pkg::CH_PERCENT) begin
                  phase_in = upd_pkg::PHASE_FIRST;
               end else begin
                  b0  = req_in_byte;
                  cnt = 2'd1;
               end
            end
            upd_pkg::PHASE_FIRST: begin
               if (hex[4]) begin
                  nib_in   = hex[3:0];
                  first_in = req_in_byte;
                  phase_in = upd_pkg::PHASE_SECOND;
               end else begin
                  bad      = 1'b1;
                  b0       = upd_pkg::CH_PERCENT;
                  b1       = req_in_byte;
                  cnt      = 2'd2;
                  phase_in = upd_pkg::PHASE_PLAIN;
               end
            end
            upd_pkg::PHASE_SECOND: begin
               phase_in = upd_pkg::PHASE_PLAIN;
               if (hex[4]) begin
                  if (letter && uri) begin
                     b0  = val;
                     cnt = 2'd1;
                     if (val == upd_pkg::CH_QUESTION) stop_in = 1'b1;
                  end else if (redir) begin
                     if (letter && val == upd_pkg::CH_QUESTION) begin
                        b0      = val;
                        cnt     = 2'd1;
                        stop_in = 1'b1;
                     end else if (val > upd_pkg::CH_PERCENT && val < upd_pkg::CH_DEL) begin
                        b0  = val;
                        cnt = 2'd1;
                     end else begin
                        b0  = upd_pkg::CH_PERCENT;
                        b1  = first_ff;
                        b2  = req_in_byte;
                        cnt = 2'd3;
                     end
                  end else begin
                     b0  = val;
                     cnt = 2'd1;
                  end
               end else begin
                  bad = 1'b1;
                  b0  = upd_pkg::CH_PERCENT;
                  b1  = upd_pkg::hex_char(nib_ff);
                  b2  = req_in_byte;
                  cnt = 2'd3;
               end
            end
            default: begin
               phase_in = upd_pkg::PHASE_PLAIN;
            end
         endcase
      end
      tally_in = (bad && tally_ff != '1) ? tally_ff + 1'b1 : tally_ff;
   end

   // report width is fixed at 16, saturated
   generate
      if (ERROR_COUNT_BITS > 16) begin : g_wide
         assign rep = (|tally_in[ERROR_COUNT_BITS-1:16]) ? 16'hffff : tally_in[15:0];
      end else begin : g_narrow
         assign rep = 16'(tally_in);
      end
   endgenerate

   assign push          = accept && (cnt != 2'd0 || req_end_of_string);
   assign job.byte0     = b0;
   assign job.byte1     = b1;
   assign job.byte2     = b2;
   assign job.count     = cnt;
   assign job.bad_count = rep;
   assign job.stop_hit  = stop_in;
   assign job.done      = req_end_of_string;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PHASE_PLAIN;
         nib_ff   <= 4'd0;
         first_ff <= 8'd0;
         tally_ff <= '0;
         stop_ff  <= 1'b0;
      end else if (accept) begin
         if (req_end_of_string) begin
            phase_ff <= upd_pkg::PHASE_PLAIN;
            nib_ff   <= 4'd0;
            first_ff <= 8'd0;
            tally_ff <= '0;
            stop_ff  <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            nib_ff   <= nib_in;
            first_ff <= first_in;
            tally_ff <= tally_in;
            stop_ff  <= stop_in;
         end
      end
   end

endmodule

[sv/upd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module upd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  upd_pkg::upd_job_type push_job,
   input  logic                 pop,
   output upd_pkg::upd_job_type head_job,
   output logic                 empty,
   output logic                 full
);

   localparam int PtrBits = $clog2(upd_pkg::QUEUE_DEPTH);
   localparam int CntBits = $clog2(upd_pkg::QUEUE_DEPTH + 1);

   upd_pkg::upd_job_type entry_ff [upd_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntBits-1:0] count_ff;
   logic do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == CntBits'(upd_pkg::QUEUE_DEPTH);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= PtrBits'((32'(wr_ptr_ff) + 1) % upd_pkg::QUEUE_DEPTH);
         if (do_pop) rd_ptr_ff <= PtrBits'((32'(rd_ptr_ff) + 1) % upd_pkg::QUEUE_DEPTH);
         if (push && !do_pop)
            count_ff <= count_ff + 1'b1;
         else if (do_pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule

[sv/upd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back
// Unrolls each job into result transactions through an output register.
// ----------------------------------------------------------------------------
module upd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  upd_pkg::upd_job_type head_job,
   input  logic                 queue_empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last_of_run,
   output logic [15:0]          rsp_bad_count,
   output logic                 rsp_stop_hit,
   output logic                 rsp_string_done
);

   logic [1:0]  idx_ff;
   logic        valid_ff;
   logic [7:0]  byte_ff, byte_sel;
   logic        bvalid_ff, last_ff, stop_ff, done_ff;
   logic [15:0] bad_ff;
   logic        load, fin;
   logic [1:0]  last_idx;

   assign load     = !valid_ff || !rsp_stall;
   assign last_idx = (head_job.count == 2'd0) ? 2'd0 : head_job.count - 2'd1;
   assign fin      = idx_ff == last_idx;
   assign pop      = load && !queue_empty && fin;

   always_comb begin
      case (idx_ff)
         2'd0:    byte_sel = head_job.byte0;
         2'd1:    byte_sel = head_job.byte1;
         2'd2:    byte_sel = head_job.byte2;
         default: byte_sel = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= !queue_empty;
         if (!queue_empty) idx_ff <= fin ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_sel;
         bvalid_ff <= head_job.count != 2'd0;
         last_ff   <= fin;
         bad_ff    <= head_job.bad_count;
         stop_ff   <= head_job.stop_hit;
         done_ff   <= fin && head_job.done;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_bad_count   = bad_ff;
   assign rsp_stop_hit    = stop_ff;
   assign rsp_string_done = done_ff;

endmodule

[sv/upd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`include "uri_percent_decoder_defines.svh"

module upd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_last_of_run,
   input logic [15:0] rsp_bad_count,
   input logic        rsp_stop_hit,
   input logic        rsp_string_done
);

   // stalled result holds
   `UPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_bad_count)
      && $stable(rsp_last_of_run) && $stable(rsp_byte_valid)
      && $stable(rsp_stop_hit) && $stable(rsp_string_done))

   // status-only result: zero byte, closes the run and the string
   `UPD_ASSERT_IMPLY(a_status_only, clock, reset, rsp_valid && !rsp_byte_valid,
      rsp_out_byte == 8'd0 && rsp_last_of_run && rsp_string_done)

   // string end only on the final result of a run
   `UPD_ASSERT_IMPLY(a_done_last, clock, reset, rsp_valid && rsp_string_done, rsp_last_of_run)

   // results inside a run always carry a byte
   `UPD_ASSERT_IMPLY(a_mid_run_byte, clock, reset, rsp_valid && !rsp_last_of_run, rsp_byte_valid)

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (.*);

[tb/sv/upd_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_check_pkg
// Expected-result tracking for the URI percent decoder bench: a bit-level
// decoder of its own that turns each accepted source byte into the results it
// should cause, and a checker that pops them as results come out.
// ----------------------------------------------------------------------------
package upd_check_pkg;
   import upd_pkg::*;

   // values of the unescape_mode register
   localparam logic [1:0] MODE_PLAIN    = 2'd0;
   localparam logic [1:0] MODE_URI      = 2'd1;
   localparam logic [1:0] MODE_REDIRECT = 2'd2;
   localparam logic [1:0] MODE_BOTH     = 2'd3;
   localparam int MODE_URI_BIT      = 0;
   localparam int MODE_REDIRECT_BIT = 1;

   localparam int TALLY_BITS   = 16;
   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_of_run;
      logic [15:0] bad_count;
      logic        stop_hit;
      logic        string_done;
   } upd_result_type;

   class upd_scoreboard;
      upd_result_type        pending_results[$];
      logic [1:0]            mode;
      upd_phase_type         phase;
      logic [3:0]            high_nib;
      logic [7:0]            first_char;
      logic [TALLY_BITS-1:0] bad_tally;
      logic                  halted;
      int                    failures;

      function new();
         mode     = MODE_PLAIN;
         failures = 0;
         clear_string();
      endfunction

      function void clear_string();
         phase      = PHASE_PLAIN;
         high_nib   = '0;
         first_char = '0;
         bad_tally  = '0;
         halted     = 1'b0;
      endfunction

      function void write_reg(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] data);
         if (addr[CSR_ADDR_BITS-1:2] == CSR_IDX_MODE)
            mode = data[1:0];
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      task report(string msg);
         failures++;
         if (failures <= REPORT_LINES)
            $display("[%0t] upd mismatch: %s", $time, msg);
      endtask

      // {is_hex, value}
      function logic [4:0] hex_digit(logic [7:0] c);
         logic [7:0] folded;
         folded = c | CH_CASE_BIT;
         if (c >= CH_ZERO && c <= CH_NINE)
            return {1'b1, 4'(c - CH_ZERO)};
         if (folded >= CH_LOWER_A && folded <= CH_LOWER_F)
            return {1'b1, 4'(folded - CH_LOWER_A + 8'(DIGIT_TEN))};
         return 5'd0;
      endfunction

      function logic [7:0] lower_digit(logic [3:0] h);
         if (h < DIGIT_TEN)
            return CH_ZERO + 8'(h);
         return CH_LOWER_A + 8'(h) - 8'(DIGIT_TEN);
      endfunction

      function void bump_tally();
         if (bad_tally != '1)
            bad_tally++;
      endfunction

      // one accepted source byte -> zero to three expected results
      function void note_byte(logic [7:0] ch, logic eos);
         logic [7:0]     run[$];
         logic [4:0]     d;
         logic [7:0]     val;
         logic           letter;
         upd_result_type r;
         if (!halted) begin
            case (phase)
               PHASE_PLAIN: begin
                  if (ch == CH_QUESTION && mode != MODE_PLAIN) begin
                     run = {run, ch};
                     halted = 1'b1;
                  end else if (ch == CH_PERCENT) begin
                     phase = PHASE_FIRST;
                  end else begin
                     run = {run, ch};
                  end
               end
               PHASE_FIRST: begin
                  d = hex_digit(ch);
                  if (d[4]) begin
                     high_nib   = d[3:0];
                     first_char = ch;
                     phase      = PHASE_SECOND;
                  end else begin
                     bump_tally();
                     run = {run, CH_PERCENT, ch};
                     phase = PHASE_PLAIN;
                  end
               end
               default: begin
                  d     = hex_digit(ch);
                  phase = PHASE_PLAIN;
                  if (d[4]) begin
                     val    = {high_nib, d[3:0]};
                     letter = d[3:0] >= DIGIT_TEN;
                     if (letter && mode[MODE_URI_BIT]) begin
                        run = {run, val};
                        if (val == CH_QUESTION)
                           halted = 1'b1;
                     end else if (mode[MODE_REDIRECT_BIT]) begin
                        if (letter && val == CH_QUESTION) begin
                           run = {run, val};
                           halted = 1'b1;
                        end else if (val > CH_PERCENT && val < CH_DEL) begin
                           run = {run, val};
                        end else begin
                           run = {run, CH_PERCENT, first_char, ch};
                        end
                     end else begin
                        run = {run, val};
                     end
                  end else begin
                     run = {run, CH_PERCENT, lower_digit(high_nib), ch};
                     bump_tally();
                  end
               end
            endcase
         end

         r.bad_count = bad_tally;
         r.stop_hit  = halted;
         if (run.size() == 0) begin
            if (eos) begin
               r.out_byte    = 8'h00;
               r.byte_valid  = 1'b0;
               r.last_of_run = 1'b1;
               r.string_done = 1'b1;
               pending_results = {pending_results, r};
            end
         end else begin
            foreach (run[k]) begin
               r.out_byte    = run[k];
               r.byte_valid  = 1'b1;
               r.last_of_run = (k == run.size() - 1);
               r.string_done = (k == run.size() - 1) && eos;
               pending_results = {pending_results, r};
            end
         end
         if (eos)
            clear_string();
      endfunction

      task check_result(upd_result_type got);
         upd_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result with nothing expected, out_byte %02h", got.out_byte));
            return;
         end
         want = pending_results.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
         if (got.byte_valid !== want.byte_valid)
            report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
         if (got.bad_count !== want.bad_count)
            report($sformatf("bad_count %0d, want %0d", got.bad_count, want.bad_count));
         if (got.stop_hit !== want.stop_hit)
            report($sformatf("stop_hit %b, want %b", got.stop_hit, want.stop_hit));
         if (got.string_done !== want.string_done)
            report($sformatf("string_done %b, want %b", got.string_done, want.string_done));
      endtask
   endclass

endpackage

[tb/sv/uri_percent_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_percent_decoder_test
// Self-checking bench for the URI percent decoder. Source strings go in one
// byte per transaction, every result transaction is compared field by field
// against the scoreboard, and the mode register is rewritten between phases.
// ----------------------------------------------------------------------------
module uri_percent_decoder_test;
   import upd_pkg::*;
   import upd_check_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int GAP_MAX        = 14;
   localparam int HOLD_CYCLES    = 64;    // long result-side hold-off
   localparam int SETTLE_CYCLES  = 8;     // covers the queue and output register
   localparam int TAIL_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_BYTES    = 57;
   localparam int PRESSURE_PHASE = 3;

   // register map: index i at byte address 4*i; index 1 is unused
   localparam logic [CSR_ADDR_BITS-1:0] MODE_ADDR  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_run;
   logic [15:0] rsp_bad_count;
   logic        rsp_stop_hit;
   logic        rsp_string_done;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   upd_scoreboard decode_sb;

   // idling controls, set by the stimulus at falling edges
   bit source_gaps  = 1'b0;
   bit sink_gaps    = 1'b0;
   bit hold_off_req = 1'b0;
   int bytes_sent   = 0;
   int quiet_cycles = 0;

   uri_percent_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_bad_count     (rsp_bad_count),
      .rsp_stop_hit      (rsp_stop_hit),
      .rsp_string_done   (rsp_string_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Result side. rsp_stall moves only at falling edges; a long hold-off
   // on request lets the decoder's job queue fill so that req_stall rises.
   // Random stall bursts come only while sink_gaps is set.
   // ------------------------------------------------------------------
   initial begin : result_sink
      int n;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (sink_gaps && !reset && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, GAP_MAX);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result transactions are sampled at the rising edge, before the
   // block's own registers move.
   always @(posedge clock) begin : result_capture
      upd_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_byte    = rsp_out_byte;
         got.byte_valid  = rsp_byte_valid;
         got.last_of_run = rsp_last_of_run;
         got.bad_count   = rsp_bad_count;
         got.stop_hit    = rsp_stop_hit;
         got.string_done = rsp_string_done;
         decode_sb.check_result(got);
      end
   end

   // Watchdog: too long with no transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** uri_percent_decoder: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Drivers. Every task starts and ends on a falling edge.
   // ------------------------------------------------------------------

   // Offer one byte and hold it until the decoder takes it.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      decode_sb.note_byte(b, eos);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic source_idle(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Whole string, end_of_string on its last byte; gaps may fall anywhere,
   // including in the middle of an escape.
   task automatic send_string(input byte_q_type text);
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
         if (source_gaps && $urandom_range(0, 7) == 0)
            source_idle($urandom_range(1, GAP_MAX));
      end
   endtask

   // Sender pauses until every expected result is back, then lets the
   // pipeline settle in case a byte with no result is still in flight.
   task automatic drain();
      req_valid <= 1'b0;
      while (decode_sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One APB transaction: setup cycle, access cycle until pready, then an
   // idle cycle so that back-to-back calls never drive psel twice at once.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr)
         decode_sb.write_reg(addr, data);
      else if (csr_prdata !== {30'd0, decode_sb.mode})
         decode_sb.report($sformatf("mode readback %08h, want %0d",
                                    csr_prdata, decode_sb.mode));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Mode change with junk in the upper data bits, then read it back.
   task automatic set_mode(input logic [1:0] m);
      logic [31:0] data;
      data      = $urandom;
      data[1:0] = m;
      drain();
      csr_access(1'b1, MODE_ADDR, data);
      csr_access(1'b0, MODE_ADDR, '0);
   endtask

   // ------------------------------------------------------------------
   // Random strings
   // ------------------------------------------------------------------

   function automatic logic [7:0] digit_char(input logic [3:0] h);
      logic [7:0] c;
      if (h < DIGIT_TEN)
         return CH_ZERO + 8'(h);
      c = CH_LOWER_A + 8'(h) - 8'(DIGIT_TEN);
      if ($urandom_range(0, 1) != 0)
         c = c & ~CH_CASE_BIT;
      return c;
   endfunction

   // Mostly well-formed escapes with values near the redirect limits,
   // plus plain text, literal question marks, raw bytes and broken escapes.
   function automatic byte_q_type random_string();
      byte_q_type s;
      logic [7:0] v;
      int pick;
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 5))
                  0: v = CH_PERCENT;
                  1: v = CH_PERCENT + 8'd1;
                  2: v = CH_DEL - 8'd1;
                  3: v = CH_DEL;
                  4: v = CH_QUESTION;
                  default: v = CH_CASE_BIT;
               endcase
            end else begin
               v = 8'($urandom);
            end
            s = {s, CH_PERCENT, digit_char(v[7:4]), digit_char(v[3:0])};
         end else if (pick < 70) begin
            s = {s, 8'($urandom_range(8'h21, 8'h7e))};
         end else if (pick < 78) begin
            s = {s, CH_QUESTION};
         end else if (pick < 88) begin
            s = {s, 8'($urandom)};
         end else if (pick < 96) begin
            // broken escape: bad first digit, or good first and random second
            s = {s, CH_PERCENT};
            if ($urandom_range(0, 1) != 0) begin
               s = {s, 8'($urandom)};
            end else begin
               s = {s, digit_char(4'($urandom)), 8'($urandom)};
            end
         end else begin
            s = {s, CH_PERCENT};   // left open if it ends the string
         end
      end
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [1:0] plan[RANDOM_PHASES];
      int start;
      plan = '{MODE_URI, MODE_BOTH, MODE_PLAIN, MODE_REDIRECT, MODE_BOTH, MODE_PLAIN};
      decode_sb = new();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: plain mode straight out of reset (readback checks the
      // reset value). Extreme bytes, upper and lower case digits, a bad
      // second digit restored in lower case, a bad first digit that is a
      // question mark (no stop), and an open escape at the end that leaves
      // a status-only result.
      csr_access(1'b0, MODE_ADDR, '0);
      send_string('{8'h00, 8'hff, "%", "4", "a", "%", "B", "g", "%", "?", "%"});

      // both modes: decoded '?' stops, the byte after it gives status only
      set_mode(MODE_BOTH);
      send_string('{"%", "3", "F", "x"});

      // redirect: %20 is kept as its three characters, %3f stops.
      // A write to the unused index must leave the mode alone.
      set_mode(MODE_REDIRECT);
      csr_access(1'b1, SPARE_ADDR, 32'hffff_ffff);
      csr_access(1'b0, MODE_ADDR, '0);
      send_string('{"%", "2", "0", "%", "3", "f", "z"});

      // random phases, one mode each
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_mode(plan[p]);
         start = bytes_sent;
         if (p == PRESSURE_PHASE) begin
            source_gaps  = 1'b0;
            sink_gaps    = 1'b0;
            hold_off_req = 1'b1;
         end
         while (bytes_sent - start < PHASE_BYTES) begin
            if (p != PRESSURE_PHASE && p != RANDOM_PHASES - 1) begin
               source_gaps = $urandom_range(0, 2) != 0;
               sink_gaps   = $urandom_range(0, 2) != 0;
            end else begin
               source_gaps = 1'b0;
               sink_gaps   = 1'b0;
            end
            send_string(random_string());
         end
      end

      req_valid <= 1'b0;
      while (decode_sb.outstanding() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (decode_sb.failures == 0)
         $display("** uri_percent_decoder: PASSED **");
      else
         $display("** uri_percent_decoder: FAILED **");
      $finish;
   end

endmodule
